@@ sv/bilinear_image_upscaler_macros.svh @@
// Assertion macros for the bilinear image upscaler.
`ifndef BILINEAR_IMAGE_UPSCALER_MACROS_SVH
`define BILINEAR_IMAGE_UPSCALER_MACROS_SVH

`ifndef SYNTH
// Check that cons holds in the same cycle as ante.
`define BILUP_ASSERT_HOLDS(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bilinear upscaler: same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define BILUP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bilinear upscaler: next-cycle check failed");
`else
`define BILUP_ASSERT_HOLDS(label, clk, rst, ante, cons)
`define BILUP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ sv/bilup_pkg.sv @@
// Shared types and constants of the bilinear image upscaler.
`default_nettype none

package bilup_pkg;

  localparam int PIX_W      = 8;
  localparam int SRC_W_W    = 11;
  localparam int HGT_W      = 13;
  localparam int SCALE_W    = 3;
  localparam int ROW_W      = 12;
  localparam int Y_W        = 14;
  localparam int DEN_Y_W    = 15;
  localparam int OUT_X_W    = 12;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_SCALE  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y       = 2'd3;

  // Sequencer states
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LOAD   = 8'b0000_0010,
    ST_DIV_Y  = 8'b0000_0100,
    ST_DIV_X  = 8'b0000_1000,
    ST_LERP_T = 8'b0001_0000,
    ST_LERP_B = 8'b0010_0000,
    ST_LERP_V = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

@@ sv/bilinear_image_upscaler.sv @@
// A pixel on the first row or column of the frame gives no output. Otherwise the block
// computes the ny by nx output pixels of the source cell, plus output stalls: the shared
// fraction divider gives each row fraction and each column fraction, the shared lerp unit
// takes three steps per pixel (top, bottom, between), then comes the output beat.
// One item at a time. Reset: frame position to row 0 column 0, the configuration
// registers to 2; the line store keeps its contents, and no clearing pass is run.
`default_nettype none
`include "bilinear_image_upscaler_macros.svh"

module bilinear_image_upscaler
  import bilup_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic [PIX_W-1:0]      pixel_value,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic [OUT_X_W-1:0]    out_x,
  output      logic [Y_W-1:0]        out_y,
  output      logic [PIX_W-1:0]      out_value,
  output      logic                  run_last
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int XW  = $clog2(4 * MAX_WIDTH);
  localparam int DW  = (XW + 1 > DEN_Y_W) ? XW + 1 : DEN_Y_W;

  // Configuration
  logic [SRC_W_W-1:0] source_width;
  logic [HGT_W-1:0]   source_height;
  logic [SCALE_W-1:0] scale_x;
  logic [SCALE_W-1:0] scale_y;

  // Frame position and sequencer
  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  state_t           state;

  // Cell corners and item flags
  logic [PIX_W-1:0] c00, c01, c10, c11;
  logic             emit_cell;
  logic             last_col;

  // Output walk
  logic [XW-1:0]  x_start, rx_start, x_pos, rem_x;
  logic [Y_W-1:0] y_start, ry_start, y_pos, rem_y;
  logic [FRAC_BITS-1:0] tx, ty;
  logic [PIX_W-1:0] top_val, bot_val, pix_val;

  // Derived geometry
  logic [WW-1:0]      w_eff;
  logic [HGT_W-1:0]   h_eff;
  logic [SCALE_W-1:0] sx_eff, sy_eff;
  logic [WW-1:0]      num_x;
  logic [XW:0]        den_x;
  logic [HGT_W-1:0]   num_y;
  logic [DEN_Y_W-1:0] den_y;
  logic [XW:0]        sum_x;
  logic [Y_W:0]       sum_y;
  logic               x_stop, y_stop;
  logic [XW-1:0]      x_rem_next;
  logic [Y_W-1:0]     y_rem_next;
  logic               col_last, row_last;
  logic [XW+OUT_X_W-1:0] x_ext;

  logic             accept;
  logic             out_load;
  logic             last_next;
  logic [PIX_W-1:0] ram_rdata;

  logic                 div_start;
  logic [DW-1:0]        div_num, div_den;
  logic                 div_done;
  logic [FRAC_BITS-1:0] div_quot;

  logic [PIX_W-1:0]     lerp_s, lerp_e, lerp_y;
  logic [FRAC_BITS-1:0] lerp_t;

  // Clamp the configuration into range
  always_comb begin
    if (source_width < SRC_W_W'(2)) begin
      w_eff = WW'(2);
    end else if (32'(source_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(source_width);
    end
    if (source_height < HGT_W'(2)) begin
      h_eff = HGT_W'(2);
    end else if (32'(source_height) > MAX_HEIGHT) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = source_height;
    end
    sx_eff = (scale_x == '0) ? SCALE_W'(1) :
             (32'(scale_x) > MAX_SCALE) ? SCALE_W'(MAX_SCALE) : scale_x;
    sy_eff = (scale_y == '0) ? SCALE_W'(1) :
             (32'(scale_y) > MAX_SCALE) ? SCALE_W'(MAX_SCALE) : scale_y;
  end

  // Rational mapping: numerators and denominators of both axes
  always_comb begin
    num_x = w_eff - WW'(1);
    den_x = (XW + 1)'(w_eff) * (XW + 1)'(sx_eff);
    num_y = h_eff - HGT_W'(1);
    den_y = DEN_Y_W'(h_eff) * DEN_Y_W'(sy_eff);
  end

  // Step the remainders; a wrap means the next output falls in the next cell
  always_comb begin
    sum_x      = {1'b0, rem_x} + (XW + 1)'(num_x);
    x_stop     = sum_x >= den_x;
    x_rem_next = x_stop ? XW'(sum_x - den_x) : XW'(sum_x);
    sum_y      = {1'b0, rem_y} + (Y_W + 1)'(num_y);
    y_stop     = sum_y >= (Y_W + 1)'(den_y);
    y_rem_next = y_stop ? Y_W'(sum_y - (Y_W + 1)'(den_y)) : Y_W'(sum_y);
    last_next  = x_stop && y_stop;
    col_last   = WW'(col) == num_x;
    row_last   = HGT_W'(row) == num_y;
    x_ext      = {{OUT_X_W{1'b0}}, x_pos};
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == ST_EMIT) && (!out_valid || !out_stall);

  // Current source row store: old value out, new pixel in, same column
  bilup_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (pixel_value),
    .raddr (col),
    .rdata (ram_rdata)
  );

  // Divider launches: row fraction, then column fraction of each output
  always_comb begin
    div_start = 1'b0;
    div_num   = DW'(rem_x);
    div_den   = DW'(den_x);
    unique case (state)
      ST_LOAD: begin
        div_start = emit_cell;
        div_num   = DW'(ry_start);
        div_den   = DW'(den_y);
      end
      ST_DIV_Y: begin
        div_start = div_done;
      end
      ST_EMIT: begin
        div_start = out_load && !last_next;
        if (x_stop) begin
          div_num = DW'(y_rem_next);
          div_den = DW'(den_y);
        end else begin
          div_num = DW'(x_rem_next);
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  bilup_frac_div #(
    .DW        (DW),
    .FRAC_BITS (FRAC_BITS)
  ) u_frac_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Lerp operands: top row, bottom row, then between the two
  always_comb begin
    case (state)
      ST_LERP_T: begin
        lerp_s = c00;
        lerp_e = c10;
        lerp_t = tx;
      end
      ST_LERP_B: begin
        lerp_s = c01;
        lerp_e = c11;
        lerp_t = tx;
      end
      default: begin
        lerp_s = top_val;
        lerp_e = bot_val;
        lerp_t = ty;
      end
    endcase
  end

  bilup_lerp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lerp (
    .s (lerp_s),
    .e (lerp_e),
    .t (lerp_t),
    .y (lerp_y)
  );

  // Configuration, frame position, sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SRC_W_W'(2);
      source_height <= HGT_W'(2);
      scale_x       <= SCALE_W'(2);
      scale_y       <= SCALE_W'(2);
      col           <= '0;
      row           <= '0;
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SOURCE_WIDTH:  source_width  <= cfg_data[SRC_W_W-1:0];
          REG_SOURCE_HEIGHT: source_height <= cfg_data[HGT_W-1:0];
          REG_SCALE_X:       scale_x       <= cfg_data[SCALE_W-1:0];
          REG_SCALE_Y:       scale_y       <= cfg_data[SCALE_W-1:0];
          default: begin
          end
        endcase
        col <= '0;
        row <= '0;
      end else if (accept) begin
        if (col_last) begin
          col <= '0;
          row <= row_last ? '0 : row + ROW_W'(1);
        end else begin
          col <= col + CW'(1);
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= emit_cell ? ST_DIV_Y : ST_IDLE;
        end
        ST_DIV_Y: begin
          if (div_done) begin
            state <= ST_DIV_X;
          end
        end
        ST_DIV_X: begin
          if (div_done) begin
            state <= ST_LERP_T;
          end
        end
        ST_LERP_T: state <= ST_LERP_B;
        ST_LERP_B: state <= ST_LERP_V;
        ST_LERP_V: state <= ST_EMIT;
        ST_EMIT: begin
          if (out_load) begin
            if (!x_stop) begin
              state <= ST_DIV_X;
            end else if (!y_stop) begin
              state <= ST_DIV_Y;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath: corners, walk positions, fractions, lerp results, output beat
  always_ff @(posedge clk) begin
    if (accept) begin
      // Shift the cell one column east
      c00       <= c10;
      c01       <= c11;
      c11       <= pixel_value;
      emit_cell <= (col != '0) && (row != '0);
      last_col  <= col_last;
      if (col == '0) begin
        x_start  <= '0;
        rx_start <= '0;
      end
      if (row == '0) begin
        y_start  <= '0;
        ry_start <= '0;
      end
    end

    unique case (state)
      ST_LOAD: begin
        c10   <= ram_rdata;
        y_pos <= y_start;
        rem_y <= ry_start;
        x_pos <= x_start;
        rem_x <= rx_start;
      end
      ST_DIV_Y: begin
        if (div_done) begin
          ty <= div_quot;
        end
      end
      ST_DIV_X: begin
        if (div_done) begin
          tx <= div_quot;
        end
      end
      ST_LERP_T: top_val <= lerp_y;
      ST_LERP_B: bot_val <= lerp_y;
      ST_LERP_V: pix_val <= lerp_y;
      ST_EMIT: begin
        if (out_load) begin
          out_x     <= x_ext[OUT_X_W-1:0];
          out_y     <= y_pos;
          out_value <= pix_val;
          run_last  <= last_next;
          if (!x_stop) begin
            x_pos <= x_pos + XW'(1);
            rem_x <= x_rem_next;
          end else if (!y_stop) begin
            y_pos <= y_pos + Y_W'(1);
            rem_y <= y_rem_next;
            x_pos <= x_start;
            rem_x <= rx_start;
          end else begin
            // Cell done: hand the walk position on to the next column and row
            x_start  <= x_pos + XW'(1);
            rx_start <= x_rem_next;
            if (last_col) begin
              y_start  <= y_pos + Y_W'(1);
              ry_start <= y_rem_next;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  `BILUP_ASSERT_NEXT(a_accept_loads, clk, rst, in_valid && !in_stall, state == ST_LOAD)
  `BILUP_ASSERT_HOLDS(a_div_done_waited, clk, rst, div_done, state == ST_DIV_Y || state == ST_DIV_X)
  `BILUP_ASSERT_HOLDS(a_rem_x_below_den, clk, rst, state == ST_DIV_X || state == ST_EMIT, (XW + 1)'(rem_x) < den_x)
  `BILUP_ASSERT_NEXT(a_last_beat_idles, clk, rst, out_load && last_next, state == ST_IDLE && run_last)

endmodule

`default_nettype wire

@@ sv/bilup_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none

module bilup_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; a read of the address being written returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/bilup_frac_div.sv @@
// Iterative restoring divider for interpolation fractions, one bit a cycle.
`default_nettype none

module bilup_frac_div
  import bilup_pkg::*;
#(
  parameter int DW        = 15,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DW-1:0]        num,
  input  wire logic [DW-1:0]        den,
  output      logic                 done,
  output      logic [FRAC_BITS-1:0] quot
);

  localparam int CNTW = $clog2(FRAC_BITS + 1);

  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   den_q;
  logic [DW:0]     rem2;
  logic            ge;
  logic [DW-1:0]   rem_step;

  // One quotient bit: double the remainder, subtract the divisor if it fits
  always_comb begin
    rem2     = {rem, 1'b0};
    ge       = rem2 >= {1'b0, den_q};
    rem_step = ge ? DW'(rem2 - {1'b0, den_q}) : DW'(rem2);
  end

  // Step count and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNTW'(FRAC_BITS);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - CNTW'(1);
      done <= (cnt == CNTW'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_q <= den;
      quot  <= '0;
    end else if (cnt != '0) begin
      rem   <= rem_step;
      quot  <= {quot[FRAC_BITS-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ sv/bilup_lerp.sv @@
// Fixed-point linear interpolation s + (e-s)*t / 2^FRAC_BITS, truncated toward zero.
`default_nettype none

module bilup_lerp
  import bilup_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  wire logic [PIX_W-1:0]     s,
  input  wire logic [PIX_W-1:0]     e,
  input  wire logic [FRAC_BITS-1:0] t,
  output      logic [PIX_W-1:0]     y
);

  localparam int PW = FRAC_BITS + PIX_W + 2;
  localparam logic [PW-1:0] BIAS = {{(PIX_W + 2){1'b0}}, {FRAC_BITS{1'b1}}};

  logic signed [PIX_W:0] d;
  logic signed [PW-1:0]  p;
  logic [PW-1:0]         adj;

  // Signed difference times fraction; bias negatives so the shift truncates toward zero
  always_comb begin
    d   = $signed({1'b0, e}) - $signed({1'b0, s});
    p   = PW'(d) * PW'($signed({1'b0, t}));
    adj = p + (p[PW-1] ? BIAS : '0);
    y   = s + adj[FRAC_BITS+PIX_W-1:FRAC_BITS];
  end

endmodule

`default_nettype wire

@@ verif/upscale_checker.sv @@
// Checker for the bilinear upscaler: predicts every output pixel and compares each beat.
`timescale 1ns / 100ps

module upscale_checker
  import bilup_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [PIX_W-1:0]      pixel_value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [OUT_X_W-1:0]    out_x,
  input  logic [Y_W-1:0]        out_y,
  input  logic [PIX_W-1:0]      out_value,
  input  logic                  run_last,
  output int                    mismatch_count,
  output int                    pixels_outstanding
);

  localparam int LINE_DEPTH = 1024;
  localparam int FRAC       = 8;
  localparam int CELL_CAP   = 64;

  typedef struct {
    logic [OUT_X_W-1:0] x;
    logic [Y_W-1:0]     y;
    logic [PIX_W-1:0]   value;
    logic               last;
  } scaled_pixel_t;

  // Shadow copy of the frame position, the two source rows and the registers
  logic [PIX_W-1:0]   upper_line [0:LINE_DEPTH-1];
  logic [PIX_W-1:0]   lower_line [0:LINE_DEPTH-1];
  logic [9:0]         src_col;
  logic [ROW_W-1:0]   src_row;
  logic [SRC_W_W-1:0] width_reg;
  logic [HGT_W-1:0]   height_reg;
  logic [SCALE_W-1:0] scale_x_reg;
  logic [SCALE_W-1:0] scale_y_reg;

  scaled_pixel_t pixels_due [$];
  scaled_pixel_t due;
  int            mismatch_total = 0;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // s + (e-s)*t/2^FRAC, the quotient truncated toward zero
  function automatic logic [PIX_W-1:0] blend(logic [PIX_W-1:0] s, logic [PIX_W-1:0] e,
                                             int unsigned t);
    int span;
    int prod;
    int delta;
    span  = int'(e) - int'(s);
    prod  = span * int'(t);
    delta = prod / (1 << FRAC);
    return PIX_W'(int'(s) + delta);
  endfunction

  // First output coordinate that falls in source cell k: ceil(k*den/num)
  function automatic int unsigned cell_start(int unsigned k, int unsigned num, int unsigned den);
    longint unsigned acc;
    acc = k;
    acc = acc * den + num - 1;
    return int'(acc / num);
  endfunction

  // Fraction of output coordinate pos within its cell, FRAC bits, truncated
  function automatic int unsigned frac_of(int unsigned pos, int unsigned num, int unsigned den);
    longint unsigned acc;
    acc = pos;
    acc = (acc * num) % den;
    return int'((acc << FRAC) / den);
  endfunction

  // Store one source pixel and queue every output pixel of the cell it completes
  task automatic predict_pixel(input logic [PIX_W-1:0] pix);
    int unsigned   w, h, sx, sy, c, r;
    int unsigned   numx, denx, numy, deny, x0, x1, y0, y1, x, y, tx, ty, n;
    logic [PIX_W-1:0] c00, c10, c01, top_v, bot_v;
    scaled_pixel_t prev;
    bit            held;
    w  = clamp_to(width_reg, 2, LINE_DEPTH);
    h  = clamp_to(height_reg, 2, MAX_HEIGHT);
    sx = clamp_to(scale_x_reg, 1, MAX_SCALE);
    sy = clamp_to(scale_y_reg, 1, MAX_SCALE);
    c  = src_col;
    r  = src_row;
    if (c >= w) c = 0;
    if (r >= h) r = 0;

    upper_line[c] = lower_line[c];
    lower_line[c] = pix;

    if (c >= 1 && r >= 1) begin
      c00  = upper_line[c-1];
      c10  = upper_line[c];
      c01  = lower_line[c-1];
      numx = w - 1;
      denx = w * sx;
      numy = h - 1;
      deny = h * sy;
      x0 = cell_start(c - 1, numx, denx);
      x1 = cell_start(c, numx, denx);
      y0 = cell_start(r - 1, numy, deny);
      y1 = cell_start(r, numy, deny);
      if (x1 > denx) x1 = denx;
      if (y1 > deny) y1 = deny;
      held = 1'b0;
      n    = 0;
      // Walk the cell row by row; hold one pixel back so the final one gets last
      for (y = y0; y < y1; y++) begin
        ty = frac_of(y, numy, deny);
        for (x = x0; x < x1 && n < CELL_CAP; x++) begin
          tx    = frac_of(x, numx, denx);
          top_v = blend(c00, c10, tx);
          bot_v = blend(c01, pix, tx);
          if (held) pixels_due = {pixels_due, prev};
          prev.x     = OUT_X_W'(x);
          prev.y     = Y_W'(y);
          prev.value = blend(top_v, bot_v, ty);
          prev.last  = 1'b0;
          held       = 1'b1;
          n++;
        end
      end
      if (held) begin
        prev.last  = 1'b1;
        pixels_due = {pixels_due, prev};
      end
    end

    // Advance the raster position, wrapping at the end of the frame
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    src_col = 10'(c);
    src_row = ROW_W'(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] upscaler check: %s got %0d expected %0d", $time, what, got, want);
    mismatch_total++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      src_col     = '0;
      src_row     = '0;
      width_reg   = SRC_W_W'(2);
      height_reg  = HGT_W'(2);
      scale_x_reg = SCALE_W'(2);
      scale_y_reg = SCALE_W'(2);
      pixels_due.delete();
    end else begin
      // Any register write restarts the frame; the line stores stay
      if (cfg_write) begin
        case (cfg_index)
          REG_SOURCE_WIDTH:  width_reg   = cfg_data[SRC_W_W-1:0];
          REG_SOURCE_HEIGHT: height_reg  = cfg_data[HGT_W-1:0];
          REG_SCALE_X:       scale_x_reg = cfg_data[SCALE_W-1:0];
          REG_SCALE_Y:       scale_y_reg = cfg_data[SCALE_W-1:0];
        endcase
        src_col = '0;
        src_row = '0;
      end

      if (in_valid && !in_stall) predict_pixel(pixel_value);

      // Compare each output beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (pixels_due.size() == 0) begin
          report_mismatch("beat with nothing due, out_x", out_x, -1);
        end else begin
          due = pixels_due.pop_front();
          if (out_x !== due.x)         report_mismatch("out_x", out_x, due.x);
          if (out_y !== due.y)         report_mismatch("out_y", out_y, due.y);
          if (out_value !== due.value) report_mismatch("out_value", out_value, due.value);
          if (run_last !== due.last)   report_mismatch("run_last", run_last, due.last);
        end
      end
    end
    mismatch_count     <= mismatch_total;
    pixels_outstanding <= pixels_due.size();
  end

endmodule

@@ verif/tb_bilinear_image_upscaler.sv @@
// Testbench top: drives source pixels, register writes and output stalls, and gives the verdict.
`timescale 1ns / 100ps

module tb_bilinear_image_upscaler;
  import bilup_pkg::*;

  localparam int MAX_GAP       = 17;
  localparam int HOLD_CYCLES   = 3000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 900;
  localparam int RANDOM_ITEMS  = 300;
  localparam int LIMIT_CYCLES  = 20_000_000;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = REG_SOURCE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      pixel_value = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [OUT_X_W-1:0]    out_x;
  logic [Y_W-1:0]        out_y;
  logic [PIX_W-1:0]      out_value;
  logic                  run_last;

  int mismatch_count;
  int pixels_outstanding;
  bit no_idle      = 1'b0;
  bit hold_off_req = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bilinear_image_upscaler DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_value (pixel_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_value   (out_value),
    .run_last    (run_last)
  );

  upscale_checker CHECK (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .pixel_value        (pixel_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_x              (out_x),
    .out_y              (out_y),
    .out_value          (out_value),
    .run_last           (run_last),
    .mismatch_count     (mismatch_count),
    .pixels_outstanding (pixels_outstanding)
  );

  // Offer one source pixel after a random gap and hold it until accepted
  task automatic send_pixel(input logic [PIX_W-1:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted pixel has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pixels_outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges
  task automatic configure(input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] hd,
                           input logic [CFG_DATA_W-1:0] sxd, input logic [CFG_DATA_W-1:0] syd);
    cfg_write <= 1'b1;
    cfg_index <= REG_SOURCE_WIDTH;
    cfg_data  <= wd;
    @(posedge clk);
    cfg_index <= REG_SOURCE_HEIGHT;
    cfg_data  <= hd;
    @(posedge clk);
    cfg_index <= REG_SCALE_X;
    cfg_data  <= sxd;
    @(posedge clk);
    cfg_index <= REG_SCALE_Y;
    cfg_data  <= syd;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Gray level biased toward black and white
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_image(input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] hd,
                           input logic [CFG_DATA_W-1:0] sxd, input logic [CFG_DATA_W-1:0] syd,
                           input int count, input bit hold);
    wait_idle();
    configure(wd, hd, sxd, syd);
    if (hold) hold_off_req = 1'b1;
    repeat (count) send_pixel(pick_pixel());
  endtask

  // Watchdog
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Output side: random stall per beat, one long hold-off on request
  initial begin : receiver
    int stall_cycles;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        stall_cycles = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end else if (no_idle) begin
        stall_cycles = 0;
      end else begin
        stall_cycles = $urandom_range(0, MAX_GAP);
      end
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int                    random_items;
    int                    phase;
    int                    count;
    logic [CFG_DATA_W-1:0] wd, hd, sxd, syd;
    random_items = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: one cell per frame, the second frame across the wrap
    send_pixel(8'd0);   send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd0);
    send_pixel(8'd255); send_pixel(8'd0);   send_pixel(8'd0);   send_pixel(8'd255);

    // Widest cell: every pixel of the 8 by 8 scaled frame from one source cell
    wait_idle();
    configure(13'd2, 13'd2, 13'd4, 13'd4);
    send_pixel(8'd0); send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd0);

    // Out-of-range width, height and scales, clamped by the block
    wait_idle();
    configure(13'd1, 13'd0, 13'd0, 13'd7);
    send_pixel(8'd255); send_pixel(8'd0); send_pixel(8'd128); send_pixel(8'd1);

    // Unit scale on a 3 by 3 frame
    wait_idle();
    configure(13'd3, 13'd3, 13'd1, 13'd1);
    send_pixel(8'd0);   send_pixel(8'd255); send_pixel(8'd0);
    send_pixel(8'd255); send_pixel(8'd0);   send_pixel(8'd255);
    send_pixel(8'd0);   send_pixel(8'd255); send_pixel(8'd0);

    // Random images, mostly small, with a pressure phase, a tall frame and a wide one
    for (phase = 0; random_items < RANDOM_ITEMS; phase++) begin
      no_idle = (phase % 5 == 3);
      if (phase == 2) begin
        run_image(13'd2, 13'd2, 13'd4, 13'd4, 24, 1'b1);
        random_items += 24;
      end else if (phase == 4) begin
        // Height and scales past their limits: the largest row denominator
        run_image(13'd2, 13'h1FFF, 13'd5, 13'd7, 24, 1'b0);
        random_items += 24;
      end else if (phase == 6) begin
        // Wider frame: a full row of cells and part of the next
        run_image(13'd40, 13'd3, 13'd3, 13'd2, 100, 1'b0);
        random_items += 100;
      end else begin
        wd    = {2'($urandom), 11'($urandom_range(0, 9))};
        hd    = 13'($urandom_range(0, 7));
        sxd   = {10'($urandom), 3'($urandom_range(0, 7))};
        syd   = {10'($urandom), 3'($urandom_range(0, 7))};
        count = $urandom_range(10, 40);
        run_image(wd, hd, sxd, syd, count, 1'b0);
        random_items += count;
      end
    end
    no_idle = 1'b0;

    // Drain, let the block settle, then give the verdict
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pixels_outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ bilinear_image_upscaler.f @@
+incdir+sv
sv/bilup_pkg.sv
sv/bilup_ram.sv
sv/bilup_frac_div.sv
sv/bilup_lerp.sv
sv/bilinear_image_upscaler.sv
verif/upscale_checker.sv
verif/tb_bilinear_image_upscaler.sv
